FILE: hw/rtl/u2k_pkg.sv
// shared types and constants for the utf-8 to key code encoder
`default_nettype none

package u2k_pkg;

  localparam int unsigned CpW      = 21;
  localparam int unsigned MaxBytes = 5;
  localparam int unsigned CntW     = 3;

  localparam logic [7:0] ZeroCode  = 8'hE0;
  localparam logic [7:0] LowZero   = 8'hE1;
  localparam logic [7:0] PrefixTag = 8'hE0;
  localparam logic [7:0] HiOffset  = 8'h40;
  localparam logic [7:0] GroupMark = 8'h80;
  localparam logic [CpW-1:0] AsciiLimit = 21'h00080;
  localparam logic [CpW-1:0] PairLow    = 21'h04000;
  localparam logic [CpW-1:0] PairHigh   = 21'h0A000;

  // finished code point handed from decoder to encoder
  typedef struct packed {
    logic           fire;
    logic [CpW-1:0] cp;
  } u2k_point_t;

  // encoded key code: byte 0 goes out first
  typedef struct packed {
    logic [MaxBytes-1:0][7:0] bytes;
    logic [CntW-1:0]          cnt;
  } u2k_word_t;

endpackage

`default_nettype wire

FILE: hw/rtl/u2k_decode.sv
// utf-8 byte decoder: code point accumulator and continuation counter
`default_nettype none

module u2k_decode (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic [7:0]         byte_i,
  input  wire logic               eok_i,
  input  wire logic               advance_i,
  output u2k_pkg::u2k_point_t     point_o
);

  logic [u2k_pkg::CpW-1:0] acc_q, acc_d, acc_n;
  logic [1:0]              rem_q, rem_d, rem_n;
  logic                    take;
  logic                    fire;

  // next accumulator from the current byte
  always_comb begin
    take  = 1'b1;
    acc_n = acc_q;
    rem_n = rem_q;
    if (rem_q != 2'd0) begin
      acc_n = {acc_q[u2k_pkg::CpW-7:0], byte_i[5:0]};
      rem_n = rem_q - 2'd1;
    end else if (byte_i[7] == 1'b0) begin
      acc_n = {13'd0, byte_i};
      rem_n = 2'd0;
    end else if (byte_i[7:5] == 3'b110) begin
      acc_n = {16'd0, byte_i[4:0]};
      rem_n = 2'd1;
    end else if (byte_i[7:4] == 4'b1110) begin
      acc_n = {17'd0, byte_i[3:0]};
      rem_n = 2'd2;
    end else if (byte_i[7:3] == 5'b11110) begin
      acc_n = {18'd0, byte_i[2:0]};
      rem_n = 2'd3;
    end else begin
      // stray lead byte, state untouched
      take = 1'b0;
    end
  end

  // code point done, or key cut short
  assign fire = take && ((rem_n == 2'd0) || eok_i);

  always_comb begin
    acc_d = acc_q;
    rem_d = rem_q;
    if (advance_i && take) begin
      if (fire) begin
        acc_d = '0;
        rem_d = 2'd0;
      end else begin
        acc_d = acc_n;
        rem_d = rem_n;
      end
    end
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
      rem_q <= 2'd0;
    end else begin
      acc_q <= acc_d;
      rem_q <= rem_d;
    end
  end

  assign point_o.fire = fire;
  assign point_o.cp   = acc_n;

endmodule

`default_nettype wire

FILE: hw/rtl/u2k_encode.sv
// code point to key code byte sequence
`default_nettype none

module u2k_encode (
  input  wire logic [u2k_pkg::CpW-1:0] cp_i,
  output u2k_pkg::u2k_word_t           word_o
);

  logic [7:0]      hi;
  logic [6:0]      grp0, grp1, grp2, grp3;
  logic [2:0]      ngrp;

  assign hi   = cp_i[15:8] + u2k_pkg::HiOffset;
  // 7-bit groups, the last one padded with zeros at the bottom
  assign grp0 = {4'd0, cp_i[20:18]};
  assign grp1 = cp_i[17:11];
  assign grp2 = cp_i[10:4];
  assign grp3 = {cp_i[3:0], 3'd0};

  always_comb begin
    if (cp_i[20:18] != 3'd0) begin
      ngrp = 3'd4;
    end else if (cp_i[17:11] != 7'd0) begin
      ngrp = 3'd3;
    end else begin
      ngrp = 3'd2;
    end
  end

  // pick the form by code point range
  always_comb begin
    word_o.bytes = '0;
    word_o.cnt   = '0;
    if (cp_i < u2k_pkg::AsciiLimit) begin
      word_o.cnt      = 3'd1;
      word_o.bytes[0] = (cp_i[6:0] == 7'd0) ? u2k_pkg::ZeroCode : cp_i[7:0];
    end else if ((cp_i >= u2k_pkg::PairLow) && (cp_i < u2k_pkg::PairHigh)) begin
      word_o.cnt = 3'd2;
      if (cp_i[7:0] == 8'd0) begin
        word_o.bytes[0] = u2k_pkg::LowZero;
        word_o.bytes[1] = hi;
      end else begin
        word_o.bytes[0] = hi;
        word_o.bytes[1] = cp_i[7:0];
      end
    end else begin
      word_o.cnt      = ngrp + 3'd1;
      word_o.bytes[0] = u2k_pkg::PrefixTag | {5'd0, ngrp};
      case (ngrp)
        3'd4: begin
          word_o.bytes[1] = u2k_pkg::GroupMark | {1'b0, grp0};
          word_o.bytes[2] = u2k_pkg::GroupMark | {1'b0, grp1};
          word_o.bytes[3] = u2k_pkg::GroupMark | {1'b0, grp2};
          word_o.bytes[4] = u2k_pkg::GroupMark | {1'b0, grp3};
        end
        3'd3: begin
          word_o.bytes[1] = u2k_pkg::GroupMark | {1'b0, grp1};
          word_o.bytes[2] = u2k_pkg::GroupMark | {1'b0, grp2};
          word_o.bytes[3] = u2k_pkg::GroupMark | {1'b0, grp3};
        end
        default: begin
          word_o.bytes[1] = u2k_pkg::GroupMark | {1'b0, grp2};
          word_o.bytes[2] = u2k_pkg::GroupMark | {1'b0, grp3};
        end
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/u2k_serializer.sv
// output buffer that sends a key code one byte per beat
`default_nettype none

module u2k_serializer (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               load_i,
  input  wire u2k_pkg::u2k_word_t word_i,
  output logic                    ready_o,
  output logic                    m_axis_tvalid_o,
  input  wire logic               m_axis_tready_i,
  output logic [7:0]              m_axis_tdata_o,   // [7:0] byte_out
  output logic                    m_axis_tlast_o    // last_of_run
);

  logic [u2k_pkg::MaxBytes-1:0][7:0] buf_q, buf_d;
  logic [u2k_pkg::CntW-1:0]          cnt_q, cnt_d;
  logic                              pop;

  assign pop     = (cnt_q != '0) && m_axis_tready_i;
  assign ready_o = (cnt_q == '0) || ((cnt_q == 3'd1) && m_axis_tready_i);

  // load a new code, or shift out one byte
  always_comb begin
    buf_d = buf_q;
    cnt_d = cnt_q;
    if (load_i) begin
      buf_d = word_i.bytes;
      cnt_d = word_i.cnt;
    end else if (pop) begin
      buf_d = {8'd0, buf_q[u2k_pkg::MaxBytes-1:1]};
      cnt_d = cnt_q - 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    buf_q <= buf_d;
  end

  assign m_axis_tvalid_o = (cnt_q != '0);
  assign m_axis_tdata_o  = buf_q[0];
  assign m_axis_tlast_o  = (cnt_q == 3'd1);

endmodule

`default_nettype wire

FILE: hw/rtl/utf8_to_key_code_encoder_core.sv
// top level: utf-8 key bytes in, key code bytes out
// path: an accepted input beat is held in the input register, then loaded into the output serializer
// throughput: one input beat per cycle while each gives at most one byte and the output is not stalled;
//   an item that gives k bytes (1 to 5) holds the input until the output serializer,
//   sending one byte per cycle while the output is ready, has sent them
// reset: rst_ni async low clears the accumulator and empties both stages
`default_nettype none

module utf8_to_key_code_encoder_core (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       s_axis_tvalid_i,
  output logic            s_axis_tready_o,
  input  wire logic [7:0] s_axis_tdata_i,   // [7:0] byte_in
  input  wire logic       s_axis_tlast_i,   // end_of_key
  output logic            m_axis_tvalid_o,
  input  wire logic       m_axis_tready_i,
  output logic [7:0]      m_axis_tdata_o,   // [7:0] byte_out
  output logic            m_axis_tlast_o    // last_of_run
);

  logic                in_vld_q, in_vld_d;
  logic [7:0]          in_byte_q;
  logic                in_eok_q;
  logic                advance;
  logic                ser_ready;
  u2k_pkg::u2k_point_t point;
  u2k_pkg::u2k_word_t  word;

  // held beat moves on when it emits nothing or the serializer has room
  assign advance         = in_vld_q && (!point.fire || ser_ready);
  assign s_axis_tready_o = !in_vld_q || advance;

  always_comb begin
    in_vld_d = in_vld_q;
    if (s_axis_tready_o) begin
      in_vld_d = s_axis_tvalid_i;
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_byte_q <= s_axis_tdata_i;
      in_eok_q  <= s_axis_tlast_i;
    end
  end

  u2k_decode u_decode (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .byte_i    (in_byte_q),
    .eok_i     (in_eok_q),
    .advance_i (advance),
    .point_o   (point)
  );

  u2k_encode u_encode (
    .cp_i   (point.cp),
    .word_o (word)
  );

  u2k_serializer u_serializer (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .load_i          (advance && point.fire),
    .word_i          (word),
    .ready_o         (ser_ready),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

endmodule

`default_nettype wire

FILE: hw/rtl/u2k_checker.sv
// port-level checks for the encoder core, bound to the top level
`default_nettype none

module u2k_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       s_axis_tready_o,
  input wire logic       m_axis_tvalid_o,
  input wire logic       m_axis_tready_i,
  input wire logic [7:0] m_axis_tdata_o,
  input wire logic       m_axis_tlast_o
);

  // stalled output beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o))
    else $error("output beat changed while stalled");

  // input only backs up behind pending output
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> m_axis_tvalid_o)
    else $error("input stalled with no output pending");

  // a run continues until its last byte
  a_run_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tready_i && !m_axis_tlast_o |=> m_axis_tvalid_o)
    else $error("output run broken before its last byte");

  // nothing comes out right after reset
  a_reset_empty: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !m_axis_tvalid_o)
    else $error("output valid right after reset");

endmodule

bind utf8_to_key_code_encoder_core u2k_checker u_u2k_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);

`default_nettype wire

FILE: verif/utf8_to_key_code_encoder_core_test.sv
// self-checking testbench for the utf-8 to key code encoder core
`timescale 1ns / 100ps

module utf8_to_key_code_encoder_core_test;

  localparam int Predicted  = -1;    // row result comes from the predictor
  localparam int StallLimit = 1000;  // cycles with no beat on either side
  localparam int HoldCycles = 80;    // long receiver hold-off
  localparam int TailCycles = 8;

  // one expected output beat
  typedef struct packed {
    logic [7:0] code;
    logic       last;
  } key_beat_t;

  // directed row: codes hold byte 0 in the low bits
  typedef struct packed {
    logic [7:0]  data;
    logic        eok;
    int          n_codes;
    logic [39:0] codes;
  } dir_row_t;

  logic       clk_i     = 1'b0;
  logic       rst_ni    = 1'b0;
  logic       in_valid  = 1'b0;
  logic [7:0] in_data   = 8'h00;
  logic       in_last   = 1'b0;
  logic       out_ready = 1'b0;
  logic       s_axis_tready_o;
  logic       m_axis_tvalid_o;
  logic [7:0] m_axis_tdata_o;
  logic       m_axis_tlast_o;

  // predictor state
  logic [u2k_pkg::CpW-1:0] cp_accum  = '0;
  logic [1:0]              cont_left = '0;
  key_beat_t               pred_beats [u2k_pkg::MaxBytes];
  int                      pred_cnt;
  key_beat_t               key_code_q [$];
  key_beat_t               oldest;

  int err_count    = 0;
  int idle_cycles  = 0;
  int hold_reqs    = 0;
  int holds_taken  = 0;
  int hold_left    = 0;
  int stall_left   = 0;
  logic src_idle_on  = 1'b0;
  logic sink_idle_on = 1'b0;

  dir_row_t dir_rows [24] = '{
    '{8'h00, 1'b0, 1, 40'hE0},          // zero becomes the zero code
    '{8'h41, 1'b0, 1, 40'h41},
    '{8'h7F, 1'b1, 1, 40'h7F},          // top ascii, key end
    '{8'h80, 1'b0, 0, 40'h0},           // stray lead, low range
    '{8'hFF, 1'b1, 0, 40'h0},           // stray lead, high range, key end
    '{8'hC2, 1'b0, 0, 40'h0},
    '{8'hA9, 1'b0, Predicted, 40'h0},   // two-byte point, prefix form
    '{8'hE4, 1'b0, 0, 40'h0},
    '{8'hB8, 1'b0, 0, 40'h0},
    '{8'h80, 1'b0, 2, 40'h8EE1},        // pair range, low byte zero
    '{8'hE9, 1'b0, 0, 40'h0},
    '{8'hBF, 1'b0, 0, 40'h0},
    '{8'hBF, 1'b0, 2, 40'hFFDF},        // top of pair range
    '{8'hF7, 1'b0, 0, 40'h0},
    '{8'hBF, 1'b0, 0, 40'h0},
    '{8'hBF, 1'b0, 0, 40'h0},
    '{8'hBF, 1'b0, Predicted, 40'h0},   // largest point, five bytes
    '{8'hE4, 1'b1, 1, 40'h04},          // multi-byte lead as last byte
    '{8'hC2, 1'b0, 0, 40'h0},
    '{8'hE4, 1'b0, Predicted, 40'h0},   // continuation that looks like a lead
    '{8'hE4, 1'b0, 0, 40'h0},
    '{8'hB8, 1'b1, Predicted, 40'h0},   // key cut short
    '{8'hC0, 1'b0, 0, 40'h0},
    '{8'h80, 1'b1, 1, 40'hE0}           // overlong zero
  };

  utf8_to_key_code_encoder_core uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (in_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (in_data),
    .s_axis_tlast_i  (in_last),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (out_ready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  // 20 ns clock
  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  task automatic report_mismatch(input string msg);
    err_count++;
    $display("mismatch at %0t ns: %s", $time, msg);
  endtask

  function automatic void put_beat(input logic [7:0] code);
    pred_beats[pred_cnt] = '{code: code, last: 1'b0};
    pred_cnt++;
  endfunction

  // decode one key byte and encode a finished code point
  task automatic predict_key_code(input logic [7:0] b, input logic eok);
    logic [u2k_pkg::CpW-1:0] u;
    logic [31:0]             w;
    logic                    took;
    int                      bits;
    int                      n;
    pred_cnt = 0;
    took = 1'b1;
    if (cont_left != 0) begin
      cp_accum  = {cp_accum[u2k_pkg::CpW-7:0], b[5:0]};
      cont_left = cont_left - 2'd1;
    end else if (!b[7]) begin
      cp_accum = {13'b0, b};
    end else if (b[7:5] == 3'b110) begin
      cp_accum  = {16'b0, b[4:0]};
      cont_left = 2'd1;
    end else if (b[7:4] == 4'b1110) begin
      cp_accum  = {17'b0, b[3:0]};
      cont_left = 2'd2;
    end else if (b[7:3] == 5'b11110) begin
      cp_accum  = {18'b0, b[2:0]};
      cont_left = 2'd3;
    end else begin
      took = 1'b0;
    end
    if (took && (cont_left == 0 || eok)) begin
      u = cp_accum;
      cp_accum  = '0;
      cont_left = '0;
      if (u < u2k_pkg::AsciiLimit) begin
        put_beat((u == 0) ? u2k_pkg::ZeroCode : u[7:0]);
      end else if (u >= u2k_pkg::PairLow && u < u2k_pkg::PairHigh) begin
        if (u[7:0] == 8'h00) begin
          put_beat(u2k_pkg::LowZero);
          put_beat(u[15:8] + u2k_pkg::HiOffset);
        end else begin
          put_beat(u[15:8] + u2k_pkg::HiOffset);
          put_beat(u[7:0]);
        end
      end else begin
        // left-justify in 7-bit groups
        w = {11'b0, u};
        bits = 32;
        while (w[31:25] == 7'd0) begin
          bits -= 7;
          w = w << 7;
        end
        n = (bits + 6) / 7;
        put_beat(u2k_pkg::PrefixTag | n[7:0]);
        repeat (n) begin
          put_beat(u2k_pkg::GroupMark | {1'b0, w[31:25]});
          w = w << 7;
        end
      end
      pred_beats[pred_cnt-1].last = 1'b1;
    end
  endtask

  // offer one input beat, wait for it to be taken, queue its results
  task automatic send_item(input logic [7:0] b, input logic eok,
                           input int n_codes, input logic [39:0] codes);
    int k;
    if (src_idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    in_last  <= eok;
    do @(posedge clk_i); while (!s_axis_tready_o);
    predict_key_code(b, eok);
    if (n_codes == Predicted) begin
      for (k = 0; k < pred_cnt; k++) key_code_q.insert(key_code_q.size(), pred_beats[k]);
    end else begin
      for (k = 0; k < n_codes; k++)
        key_code_q.insert(key_code_q.size(),
                          key_beat_t'{code: codes[8*k +: 8], last: (k == n_codes - 1)});
    end
  endtask

  // keys of mostly well-formed code points, some noise and cut-off tails
  task automatic send_random_keys(input int target);
    logic [7:0] kb [$];
    int sent;
    int cps;
    int len;
    int i;
    int j;
    sent = 0;
    while (sent < target) begin
      kb.delete();
      cps = $urandom_range(1, 4);
      for (i = 0; i < cps; i++) begin
        if ($urandom_range(0, 9) == 0) begin
          kb.insert(kb.size(), 8'($urandom_range(0, 255)));
        end else begin
          len = $urandom_range(1, 4);
          case (len)
            1: begin
              kb.insert(kb.size(), 8'($urandom_range(0, 127)));
            end
            2: begin
              kb.insert(kb.size(), 8'hC0 | 8'($urandom_range(0, 31)));
            end
            3: begin
              kb.insert(kb.size(), 8'hE0 | 8'($urandom_range(0, 15)));
            end
            default: begin
              kb.insert(kb.size(), 8'hF0 | 8'($urandom_range(0, 7)));
            end
          endcase
          for (j = 1; j < len; j++)
            kb.insert(kb.size(), ($urandom_range(0, 7) == 0) ?
                      8'h80 : (8'h80 | 8'($urandom_range(0, 63))));
        end
      end
      if ($urandom_range(0, 7) == 0 && kb.size() > 1) void'(kb.pop_back());
      for (i = 0; i < kb.size(); i++)
        send_item(kb[i], (i == kb.size() - 1), Predicted, 40'h0);
      sent += kb.size();
    end
  endtask

  // receiver: long hold-off on request, random stall bursts otherwise
  always @(posedge clk_i) begin
    if (hold_reqs != holds_taken) begin
      holds_taken <= hold_reqs;
      hold_left   <= HoldCycles - 1;
      out_ready   <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if (sink_idle_on && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 11);
      out_ready  <= 1'b0;
    end else begin
      out_ready <= rst_ni;
    end
  end

  // output check against the oldest expected beat
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && out_ready) begin
      if (key_code_q.size() == 0) begin
        report_mismatch($sformatf("unexpected beat %02h last %b",
                                  m_axis_tdata_o, m_axis_tlast_o));
      end else begin
        oldest = key_code_q.pop_front();
        if (m_axis_tdata_o !== oldest.code)
          report_mismatch($sformatf("byte_out %02h, want %02h", m_axis_tdata_o, oldest.code));
        if (m_axis_tlast_o !== oldest.last)
          report_mismatch($sformatf("last_of_run %b, want %b", m_axis_tlast_o, oldest.last));
      end
    end
  end

  // watchdog on cycles with no beat moving
  always @(posedge clk_i) begin
    if ((in_valid && s_axis_tready_o) || (m_axis_tvalid_o && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= StallLimit) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // stimulus sequence
  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni       <= 1'b1;
    src_idle_on  <= 1'b1;
    sink_idle_on <= 1'b1;
    @(posedge clk_i);

    // directed rows
    foreach (dir_rows[r])
      send_item(dir_rows[r].data, dir_rows[r].eok, dir_rows[r].n_codes, dir_rows[r].codes);

    send_random_keys(200);

    // sender pause until the output side is drained
    in_valid <= 1'b0;
    do @(posedge clk_i); while (key_code_q.size() != 0);

    // long receiver hold-off while input keeps coming
    hold_reqs <= hold_reqs + 1;
    send_random_keys(100);

    // no idling on either side
    src_idle_on  <= 1'b0;
    sink_idle_on <= 1'b0;
    send_random_keys(100);

    in_valid <= 1'b0;
    do @(posedge clk_i); while (key_code_q.size() != 0);
    repeat (TailCycles) @(posedge clk_i);
    if (err_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
